@@ hw/rtl/ssd_pkg.sv @@
// ============================================================================
// ssd_pkg: shared types and constants of the seven-segment scan driver
// Holds the op codes, the word layouts, the segment decode and the constant
// dividers that split a binary value into decimal digits.
// ============================================================================
`default_nettype none

package ssd_pkg;

    // Op codes carried in the input tuser.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // Word layouts.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned EN_W      = 4;
    localparam int unsigned VALUE_W   = 16;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_BIG_E = 8'h45;
    localparam logic [CHAR_W-1:0] CHAR_SMALL_R = 8'h72;

    typedef logic [SEG_W-1:0] t_seg;
    typedef logic [CHAR_W-1:0] t_char;

    // Active-high patterns for '0' through '9', bit 0 is segment a.
    localparam t_seg DIGIT_PAT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam t_seg PAT_MINUS = 7'h40;
    localparam t_seg PAT_BIG_E = 7'h79;
    localparam t_seg PAT_SMALL_R = 7'h50;
    localparam t_seg PAT_BLANK = 7'h00;

    // Maps a character code to its segment pattern; anything unknown is blank.
    function automatic t_seg decode_char(input t_char code);
        t_seg pat;
        pat = PAT_BLANK;
        if (code inside {[8'h30:8'h39]}) begin
            pat = DIGIT_PAT[code[3:0]];
        end else if (code == CHAR_MINUS) begin
            pat = PAT_MINUS;
        end else if (code == CHAR_BIG_E) begin
            pat = PAT_BIG_E;
        end else if (code == CHAR_SMALL_R) begin
            pat = PAT_SMALL_R;
        end
        return pat;
    endfunction

    // Exact floor(v / 10**k) for any 16-bit v, by a reciprocal multiply.
    // The shift of each divisor is chosen so the rounding error never reaches
    // the next integer over the full 16-bit range.
    function automatic logic [VALUE_W-1:0] div_pow10(input logic [VALUE_W-1:0] v,
                                                      input int unsigned k);
        logic [47:0]        prod;
        logic [VALUE_W-1:0] q;
        prod = '0;
        q    = '0;
        case (k)
            0: begin
                q = v;
            end
            1: begin
                prod = 48'(v) * 48'd52429;
                q    = prod[34:19];
            end
            2: begin
                prod = 48'(v) * 48'd83887;
                q    = prod[38:23];
            end
            3: begin
                prod = 48'(v) * 48'd67109;
                q    = prod[41:26];
            end
            4: begin
                prod = 48'(v) * 48'd107375;
                q    = prod[45:30];
            end
            default: begin
                q = '0;
            end
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssd_bin2dec.sv @@
// ============================================================================
// ssd_bin2dec: binary value to decimal character row
// Splits a 16-bit value into NUM_DIGITS ASCII digits, most significant digit
// in slot 0, with the higher decimal digits dropped.
// ============================================================================
`default_nettype none

module ssd_bin2dec
    import ssd_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  wire logic [VALUE_W-1:0]           i_value,
    output logic      [NUM_DIGITS*CHAR_W-1:0] o_chars  // slot j at bits [j*8 +: 8]
);

    // Every quotient is computed from the value directly, so all digits come
    // out of parallel constant multiplies; a digit is q_k - 10 * q_(k+1).
    for (genvar g_k = 0; g_k < NUM_DIGITS; g_k++) begin : g_digit
        logic [VALUE_W-1:0] w_q_lo;
        logic [VALUE_W-1:0] w_q_hi;
        logic [VALUE_W-1:0] w_rem;

        always_comb begin
            w_q_lo = div_pow10(i_value, g_k);
            w_q_hi = div_pow10(i_value, g_k + 1);
            w_rem  = w_q_lo - ((w_q_hi << 3) + (w_q_hi << 1));
        end

        assign o_chars[(NUM_DIGITS-1-g_k)*CHAR_W +: CHAR_W] = {4'h3, w_rem[3:0]};
    end

endmodule

`default_nettype wire

@@ hw/rtl/seven_segment_scan_driver_core.sv @@
// ============================================================================
// seven_segment_scan_driver_core: multiplexed seven-segment display driver
// Holds one character per digit and, on each scan tick, drives the segment
// pattern and one-hot enable of the next digit in turn.
// ============================================================================
// Usage:
// Commands arrive on the slave stream. tuser carries the op: write one
// character, load a decimal number, or scan tick. tdata carries the digit
// index, the character code and the 16-bit number. Only a scan tick yields
// a word on the master stream, holding the segment pattern and the one-hot
// digit enable, with tlast marking the rightmost digit of the display.
// An accepted command is held in the input register; a scan tick leaving it
// loads the result register, which presents its word on the master side.
// Throughput: one command per cycle; the decimal split and the character
// decode are shallow logic between the input register and the result
// register, and writes and loads update the slots in order as they leave
// the input register. When the receiver stalls, the scan word waits in the
// result register; the input register still takes and retires writes and
// loads, and only a scan tick behind a held word waits, which then backs up
// tready. Reset empties both registers, fills every slot with a space and
// returns the scan to digit 0.
// ============================================================================
`default_nettype none

module seven_segment_scan_driver_core
    import ssd_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Command stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: digit_index[3:0], char_code[11:4], number_value[27:12], zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]           s_axis_tuser,
    // Scan stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: segments[6:0], digit_enable[10:7], zero fill
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int unsigned POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

    // Input register.
    logic               r_in_valid;
    logic [1:0]         r_op;
    logic [3:0]         r_idx;
    t_char              r_code;
    logic [VALUE_W-1:0] r_value;

    // Display state.
    t_char              r_slots [NUM_DIGITS];
    logic [POS_W-1:0]   r_scan_pos;
    logic [POS_W-1:0]   n_scan_pos;

    // Result register.
    logic               r_out_valid;
    t_seg               r_seg;
    logic [EN_W-1:0]    r_en;
    logic               r_last;
    t_seg               n_seg;
    logic [EN_W-1:0]    n_en;
    logic               n_last;

    logic               w_in_take;
    logic               w_exec;
    logic               w_do_write;
    logic               w_do_load;
    logic               w_do_scan;
    t_char              w_cur_char;
    logic [NUM_DIGITS*CHAR_W-1:0] w_dec_chars;

    // A command leaves the input register unless it is a scan tick that
    // finds the result register still held by the receiver.
    assign w_exec     = r_in_valid &&
                        ((r_op != OP_SCAN) || !r_out_valid || m_axis_tready);
    assign w_in_take  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_in_valid || w_exec;

    always_comb begin
        w_do_write = 1'b0;
        w_do_load  = 1'b0;
        w_do_scan  = 1'b0;
        case (r_op)
            OP_WRITE: w_do_write = w_exec;
            OP_LOAD:  w_do_load  = w_exec;
            OP_SCAN:  w_do_scan  = w_exec;
            default:  begin
                w_do_write = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= s_axis_tuser;
            r_idx   <= s_axis_tdata[3:0];
            r_code  <= s_axis_tdata[11:4];
            r_value <= s_axis_tdata[27:12];
        end
    end

    ssd_bin2dec #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bin2dec (
        .i_value (r_value),
        .o_chars (w_dec_chars)
    );

    // Each slot takes a write aimed at it or its digit of a number load.
    // An index past the last digit matches no slot and is dropped.
    for (genvar g_s = 0; g_s < NUM_DIGITS; g_s++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slots[g_s] <= CHAR_SPACE;
            end else if (w_do_write && (r_idx == 4'(g_s))) begin
                r_slots[g_s] <= r_code;
            end else if (w_do_load) begin
                r_slots[g_s] <= w_dec_chars[g_s*CHAR_W +: CHAR_W];
            end
        end
    end

    // Character under the scan pointer.
    always_comb begin
        w_cur_char = CHAR_SPACE;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_scan_pos == POS_W'(i)) begin
                w_cur_char = r_slots[i];
            end
        end
    end

    // Scan word. The enable field has four bits, so a fifth digit, if
    // configured, drives an all-zero enable.
    always_comb begin
        n_seg  = decode_char(w_cur_char);
        n_last = (r_scan_pos == LAST_POS);
        for (int b = 0; b < EN_W; b++) begin
            n_en[b] = (b < NUM_DIGITS) && (r_scan_pos == POS_W'(b));
        end
        n_scan_pos = n_last ? '0 : r_scan_pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos <= '0;
        end else if (w_do_scan) begin
            r_scan_pos <= n_scan_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_do_scan) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_scan) begin
            r_seg  <= n_seg;
            r_en   <= n_en;
            r_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_en, r_seg};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

@@ hw/rtl/ssd_checker.sv @@
// ============================================================================
// ssd_checker: port-level checks of the seven-segment scan driver
// Watches both streams for reset behavior, and the scan stream for word
// stability, at most one enabled digit and the agreement of the enable with tlast.
// ============================================================================
`default_nettype none

module ssd_checker
    import ssd_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 4
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tlast
);

    // Enable pattern of the rightmost digit; zero when it lies past bit 3.
    localparam logic [EN_W-1:0] LAST_EN = EN_W'(1 << (NUM_DIGITS - 1));

    // Reset leaves no scan word pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("scan word valid after reset");

    // Reset leaves the input register empty, so the command stream is ready.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("command stream not ready after reset");

    // A held scan word does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled scan word changed");

    // At most one digit is enabled per word.
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[10:7]))
        else $error("more than one digit enabled");

    // tlast marks exactly the rightmost digit.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[10:7] == LAST_EN)))
        else $error("tlast disagrees with digit enable");

endmodule

bind seven_segment_scan_driver_core ssd_checker #(
    .NUM_DIGITS (NUM_DIGITS)
) u_ssd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ verif/tb_seven_segment_scan_driver_core.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_seven_segment_scan_driver_core: self-checking bench for the scan driver
// Sends write, load, scan and unused commands on the slave stream. A shadow
// copy of the character slots and the scan position predicts every scan word.
// Each word on the master stream is checked against the oldest prediction,
// with random gaps on the sender and random stalls on the receiver.
// ============================================================================
module tb_seven_segment_scan_driver_core;
    import ssd_pkg::*;

    localparam int unsigned DIGITS        = 4;
    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned RANDOM_ITEMS  = 360;
    localparam int unsigned TAIL_ITEMS    = 60;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned SETTLE_CYCLES = 8;
    // Watchdog bound on the run, in clock periods.
    localparam int unsigned LIMIT_CYCLES  = 200000;

    // The op code the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam t_char CHAR_ZERO    = 8'h30;
    localparam t_char CHAR_NINE    = 8'h39;
    localparam t_char CHAR_EIGHT   = 8'h38;
    localparam t_char CHAR_UNKNOWN = 8'h41;
    localparam t_char CHAR_HIGH    = 8'h80;
    localparam t_char CHAR_TOP     = 8'hFF;
    localparam t_char CHAR_NUL     = 8'h00;

    // Active-high patterns of '0' through '9', bit 0 is segment a.
    localparam t_seg SEG_DIGITS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam t_seg SEG_MINUS   = 7'h40;
    localparam t_seg SEG_BIG_E   = 7'h79;
    localparam t_seg SEG_SMALL_R = 7'h50;
    localparam t_seg SEG_BLANK   = 7'h00;

    typedef struct packed {
        t_seg            segments;
        logic [EN_W-1:0] enable;
        logic            last;
    } t_scan_word;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: digit_index[3:0], char_code[11:4], number_value[27:12], zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // tuser: op[1:0]
    logic [1:0]           s_axis_tuser  = OP_WRITE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: segments[6:0], digit_enable[10:7], zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // Shadow of the display state as the block should hold it.
    t_char       shadow_chars [DIGITS];
    int unsigned shadow_pos;

    // Scan words predicted but not yet seen, oldest first.
    t_scan_word  scan_words_due [$];

    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned fail_count = 0;
    int unsigned words_checked = 0;
    int unsigned ops_sent [4] = '{0, 0, 0, 0};

    seven_segment_scan_driver_core #(
        .NUM_DIGITS    (DIGITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Segment pattern that a character code should light up. Codes outside
    // the table, including every code of 128 or more, come out blank.
    function automatic t_seg segment_pattern(input t_char code);
        t_seg pat;
        pat = SEG_BLANK;
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            pat = SEG_DIGITS[code - CHAR_ZERO];
        end else if (code == CHAR_MINUS) begin
            pat = SEG_MINUS;
        end else if (code == CHAR_BIG_E) begin
            pat = SEG_BIG_E;
        end else if (code == CHAR_SMALL_R) begin
            pat = SEG_SMALL_R;
        end
        return pat;
    endfunction

    // Applies one accepted command to the shadow state and queues the scan
    // word that a scan tick must produce.
    task automatic apply_display_command(input logic [1:0] op, input logic [3:0] idx,
                                         input t_char code, input logic [15:0] value);
        int unsigned rest;
        t_scan_word  word;
        rest = value;
        case (op)
            OP_WRITE: begin
                // A write to a slot past the last digit is dropped.
                if (idx < DIGITS) begin
                    shadow_chars[idx] = code;
                end
            end
            OP_LOAD: begin
                // Rightmost slot takes the least significant digit; digits
                // beyond the display width fall away.
                for (int i = DIGITS - 1; i >= 0; i--) begin
                    shadow_chars[i] = CHAR_ZERO + t_char'(rest % 10);
                    rest = rest / 10;
                end
            end
            OP_SCAN: begin
                word.segments = segment_pattern(shadow_chars[shadow_pos]);
                word.enable   = '0;
                if (shadow_pos < EN_W) begin
                    word.enable[shadow_pos] = 1'b1;
                end
                word.last = (shadow_pos == DIGITS - 1);
                scan_words_due.push_back(word);
                shadow_pos = (shadow_pos + 1 >= DIGITS) ? 0 : shadow_pos + 1;
            end
            default: begin
                // The unused op leaves everything alone.
            end
        endcase
    endtask

    function automatic void note_failure(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        fail_count++;
    endfunction

    // Presents one command word and holds it until the block takes it. An
    // optional gap in front drops tvalid for a random burst.
    task automatic send_command(input logic [1:0] op, input logic [3:0] idx,
                                input t_char code, input logic [15:0] value);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, value, code, idx};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        apply_display_command(op, idx, code, value);
        ops_sent[op]++;
    endtask

    // Lowers tvalid and waits until every predicted scan word has arrived.
    // The first edge is always taken so tvalid never sees two updates at once.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (scan_words_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly characters the table knows, sometimes any code at all.
    function automatic t_char pick_char();
        t_char code;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5: code = CHAR_ZERO + t_char'($urandom_range(0, 9));
            6:       code = CHAR_SPACE;
            7:       code = CHAR_MINUS;
            8:       code = CHAR_BIG_E;
            9:       code = CHAR_SMALL_R;
            default: code = t_char'($urandom_range(0, 255));
        endcase
        return code;
    endfunction

    // Half the loads fit the display, the rest may take any 16-bit value.
    function automatic logic [15:0] pick_value();
        logic [15:0] value;
        if ($urandom_range(0, 1) == 0) begin
            value = 16'($urandom_range(0, 9999));
        end else begin
            value = 16'($urandom_range(0, 65535));
        end
        return value;
    endfunction

    // Unused fields carry random bits so that their tdata bits toggle.
    function automatic logic [15:0] noise16();
        return 16'($urandom_range(0, 65535));
    endfunction

    // Right after reset every slot holds a space and the scan starts at
    // digit 0, so the first tick must be blank on the leftmost digit.
    task automatic test_reset_state();
        send_command(OP_SCAN, 4'($urandom_range(0, 15)), pick_char(), noise16());
    endtask

    // A nine and each non-digit entry of the table, then one full sweep of the display.
    task automatic test_table_chars();
        send_command(OP_WRITE, 4'd0, CHAR_NINE, noise16());
        send_command(OP_WRITE, 4'd1, CHAR_MINUS, noise16());
        send_command(OP_WRITE, 4'd2, CHAR_BIG_E, noise16());
        send_command(OP_WRITE, 4'd3, CHAR_SMALL_R, noise16());
        repeat (DIGITS) send_command(OP_SCAN, 4'd0, CHAR_NUL, 16'h0000);
    endtask

    // Unlisted and high codes show blank, writes past the last slot and the
    // unused op leave the slots as they are.
    task automatic test_blank_and_range();
        send_command(OP_WRITE, 4'd0, CHAR_HIGH, 16'h0000);
        send_command(OP_WRITE, 4'd1, CHAR_TOP, 16'hFFFF);
        send_command(OP_WRITE, 4'd2, CHAR_UNKNOWN, 16'h0000);
        send_command(OP_WRITE, 4'd3, CHAR_NUL, 16'h0000);
        send_command(OP_WRITE, 4'd4, CHAR_EIGHT, 16'h0000);
        send_command(OP_WRITE, 4'd15, CHAR_EIGHT, 16'hFFFF);
        send_command(OP_UNUSED, 4'd15, CHAR_TOP, 16'hFFFF);
        repeat (DIGITS) send_command(OP_SCAN, 4'd15, CHAR_TOP, 16'hFFFF);
    endtask

    // The largest value overflows four digits and must show its low part.
    task automatic test_load_number();
        send_command(OP_LOAD, 4'd15, CHAR_TOP, 16'hFFFF);
        repeat (DIGITS) send_command(OP_SCAN, 4'd0, CHAR_NUL, 16'h0000);
    endtask

    // Most of the traffic fills the display and then scans it one or two
    // times around; the rest is single commands with fully random fields.
    task automatic test_random_traffic(input int unsigned target);
        int unsigned sent;
        int unsigned scans;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_command(OP_LOAD, 4'($urandom_range(0, 15)), pick_char(),
                                 pick_value());
                    sent++;
                end else begin
                    for (int d = 0; d < DIGITS; d++) begin
                        send_command(OP_WRITE, 4'(d), pick_char(), noise16());
                        sent++;
                    end
                end
                scans = $urandom_range(DIGITS, 2 * DIGITS);
                repeat (scans) begin
                    send_command(OP_SCAN, 4'($urandom_range(0, 15)),
                                 t_char'($urandom_range(0, 255)), noise16());
                    sent++;
                end
            end else begin
                send_command(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                             t_char'($urandom_range(0, 255)), noise16());
                sent++;
            end
        end
    endtask

    // Final stretch with a steady sender and an always-ready receiver.
    task automatic test_back_to_back(input int unsigned target);
        idle_on = 1'b0;
        test_random_traffic(target);
    endtask

    // Receiver: ready most of the time, with random stall bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Checker: every word taken from the master stream is matched against the
    // oldest prediction, field by field.
    always @(posedge i_clk) begin
        t_scan_word got;
        t_scan_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.segments = m_axis_tdata[SEG_W-1:0];
            got.enable   = m_axis_tdata[SEG_W+EN_W-1:SEG_W];
            got.last     = m_axis_tlast;
            if (scan_words_due.size() == 0) begin
                note_failure($sformatf("unexpected word seg=%h en=%b last=%b",
                                       got.segments, got.enable, got.last));
            end else begin
                want = scan_words_due.pop_front();
                words_checked++;
                if (got.segments !== want.segments || got.enable !== want.enable ||
                    got.last !== want.last) begin
                    note_failure($sformatf(
                        "seg exp %h got %h, en exp %b got %b, last exp %b got %b",
                        want.segments, got.segments, want.enable, got.enable,
                        want.last, got.last));
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < DIGITS; i++) begin
            shadow_chars[i] = CHAR_SPACE;
        end
        shadow_pos = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_table_chars();
        test_blank_and_range();
        test_load_number();
        test_random_traffic(RANDOM_ITEMS / 2);
        // Let the block run dry once in the middle of the random traffic.
        wait_drained();
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_drained();
        test_back_to_back(TAIL_ITEMS);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d writes, %0d loads, %0d scan ticks and %0d unused ops.",
                 ops_sent[OP_WRITE], ops_sent[OP_LOAD], ops_sent[OP_SCAN],
                 ops_sent[OP_UNUSED]);
        $display("Compared %0d scan words, %0d failures.", words_checked, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d scan words outstanding.", scan_words_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
